### design/hbt_pkg.sv
// hbt_pkg: shared constants, controller states and command/status structs
// for the bright-level histogram threshold block
// no dependencies
package hbt_pkg;

    localparam int HbtBins      = 256;
    localparam int HbtCountBits = 21;
    localparam int PixelBits    = 8;
    localparam int LevelBits    = 8;
    localparam int SumBits      = 22;
    localparam int BudgetBits   = 21;
    localparam int ApbDataBits  = 32;
    localparam int ApbAddrBits  = 3;

    localparam logic [BudgetBits-1:0] BudgetReset = BudgetBits'(628);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_SCAN,
        ST_EMIT
    } hbt_state_t;

    // controller to datapath
    typedef struct packed {
        logic acc_en;      // pixel item taken this cycle
        logic scan_init;   // reset scan pointer and running sum
        logic scan_en;     // scan results may be evaluated
        logic scan_rd;     // issue one bin read of the scan
        logic load_out;    // move the found level into the output register
        logic clear_hist;  // drop all bins for the next frame
    } hbt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic wr_pend;     // a bin update is still in flight
        logic scan_more;   // bins left to read
        logic scan_done;   // level found or bottom bin reached
        logic out_free;    // output register can take a level
    } hbt_sts_t;

endpackage

### design/hbt_cfg.sv
// hbt_cfg: apb register file holding the pixel budget
// depends on hbt_pkg
module hbt_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hbt_pkg::ApbAddrBits-1:0]     paddr,
    input  logic [hbt_pkg::ApbDataBits-1:0]     pwdata,
    output logic [hbt_pkg::ApbDataBits-1:0]     prdata,
    output logic                                pready,
    output logic [hbt_pkg::BudgetBits-1:0]      pixel_budget
);
    import hbt_pkg::*;

    logic [BudgetBits-1:0] budget_reg;
    logic                  wr_en;

    // register 0 at byte offset 0, anything at offset 4 is ignored
    assign wr_en  = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BudgetReset;
        end
        else if (wr_en)
        begin
            budget_reg <= pwdata[BudgetBits-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (!paddr[2])
        begin
            prdata = ApbDataBits'(budget_reg);
        end
    end

    assign pixel_budget = budget_reg;

endmodule

### design/hbt_ctrl.sv
// hbt_ctrl: frame sequencer (accumulate, drain, scan, emit)
// depends on hbt_pkg
module hbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  hbt_pkg::hbt_sts_t sts,
    output hbt_pkg::hbt_cmd_t cmd
);
    import hbt_pkg::*;

    hbt_state_t state_reg;
    hbt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                s_tready   = 1'b1;
                cmd.acc_en = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last bin update lands this cycle
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                cmd.scan_rd = sts.scan_more;
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.clear_hist = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

`ifndef SYNTH
    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("item taken right after end of frame");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("level loaded over an untaken result");

    a_clear_after_writes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_hist |-> !sts.wr_pend)
        else $error("histogram cleared with a bin update in flight");

    a_scan_not_in_accum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> !cmd.acc_en)
        else $error("scan read collides with pixel read");
`endif

endmodule

### design/hbt_dp.sv
// hbt_dp: bin memory with read-modify-write update, descending scan with
// saturating running sum, and output register
// depends on hbt_pkg
module hbt_dp #(
    parameter int BINS       = hbt_pkg::HbtBins,
    parameter int COUNT_BITS = hbt_pkg::HbtCountBits
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [hbt_pkg::PixelBits-1:0]     pixel,
    input  logic [hbt_pkg::BudgetBits-1:0]    pixel_budget,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [hbt_pkg::LevelBits-1:0]     level,
    input  hbt_pkg::hbt_cmd_t                 cmd,
    output hbt_pkg::hbt_sts_t                 sts
);
    import hbt_pkg::*;

    localparam int AW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int AddW = ((COUNT_BITS > SumBits) ? COUNT_BITS : SumBits) + 1;
    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
    localparam logic [SumBits-1:0]    SumMax   = {SumBits{1'b1}};
    localparam logic [AW-1:0]         TopBin   = AW'(BINS - 1);
    localparam logic [AW-1:0]         BotBin   = AW'(1);

    // bin storage, validity in flip-flops so a frame clear drops every bin at once
    logic [COUNT_BITS-1:0] bin_mem [BINS];
    logic [BINS-1:0]       bin_vld_reg;

    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;
    logic                  hit_reg;
    logic [COUNT_BITS-1:0] last_wdata_reg;

    logic                  acc_v_reg;
    logic [AW-1:0]         acc_addr_reg;

    logic [AW-1:0]         scan_addr_reg;
    logic                  scan_v_reg;
    logic [AW-1:0]         scan_s1_addr_reg;
    logic [SumBits-1:0]    sum_reg;
    logic [AW-1:0]         level_res_reg;

    logic                  out_valid_reg;
    logic [LevelBits-1:0]  out_level_reg;

    logic [AW-1:0]         pix_addr;
    logic [AW-1:0]         rd_addr;
    logic                  rd_en;
    logic [COUNT_BITS-1:0] old_count;
    logic [COUNT_BITS-1:0] wdata;
    logic [AddW-1:0]       sum_add;
    logic [SumBits-1:0]    sum_sat;
    logic                  exceed;
    logic                  scan_fire;
    logic                  scan_done;
    logic                  out_free;

    // pixels above the top bin fall into it
    always_comb
    begin
        if ({1'b0, pixel} > (PixelBits + 1)'(BINS - 1))
        begin
            pix_addr = TopBin;
        end
        else
        begin
            pix_addr = AW'(pixel);
        end
    end

    assign rd_en   = cmd.acc_en || cmd.scan_rd;
    assign rd_addr = cmd.scan_rd ? scan_addr_reg : pix_addr;

    // bypass when the bin read was overtaken by a write at the same edge
    assign old_count = hit_reg ? last_wdata_reg : (rd_vld_reg ? rd_data_reg : '0);
    assign wdata     = (old_count == CountMax) ? old_count : old_count + 1'b1;

    always_ff @(posedge clk)
    begin
        if (acc_v_reg)
        begin
            bin_mem[acc_addr_reg] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= bin_mem[rd_addr];
        end
        last_wdata_reg <= wdata;
    end

    assign sum_add = AddW'(sum_reg) + AddW'(old_count);
    assign sum_sat = (sum_add > AddW'(SumMax)) ? SumMax : sum_add[SumBits-1:0];
    assign exceed  = sum_sat > SumBits'(pixel_budget);

    assign scan_fire = cmd.scan_en && scan_v_reg;
    assign scan_done = scan_fire && (exceed || (scan_s1_addr_reg == BotBin));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg      <= '0;
            rd_vld_reg       <= 1'b0;
            hit_reg          <= 1'b0;
            acc_v_reg        <= 1'b0;
            acc_addr_reg     <= '0;
            scan_addr_reg    <= TopBin;
            scan_v_reg       <= 1'b0;
            scan_s1_addr_reg <= TopBin;
            sum_reg          <= '0;
            level_res_reg    <= TopBin;
            out_valid_reg    <= 1'b0;
            out_level_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_hist)
            begin
                bin_vld_reg <= '0;
            end
            else if (acc_v_reg)
            begin
                bin_vld_reg[acc_addr_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= bin_vld_reg[rd_addr];
            end
            hit_reg      <= cmd.acc_en && acc_v_reg && (acc_addr_reg == pix_addr);
            acc_v_reg    <= cmd.acc_en;
            acc_addr_reg <= pix_addr;

            if (cmd.scan_init)
            begin
                scan_addr_reg <= TopBin;
                scan_v_reg    <= 1'b0;
                sum_reg       <= '0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_addr_reg    <= scan_addr_reg - 1'b1;
                    scan_s1_addr_reg <= scan_addr_reg;
                end
                scan_v_reg <= cmd.scan_rd;
                if (scan_fire)
                begin
                    sum_reg <= sum_sat;
                end
            end
            if (scan_done)
            begin
                level_res_reg <= exceed ? scan_s1_addr_reg : TopBin;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
                out_level_reg <= LevelBits'(level_res_reg);
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    assign sts.wr_pend   = acc_v_reg;
    assign sts.scan_more = scan_addr_reg != '0;
    assign sts.scan_done = scan_done;
    assign sts.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign level    = out_level_reg;

endmodule

### design/histogram_bright_threshold.sv
// histogram_bright_threshold: top level joining register file, sequencer
// and datapath; depends on hbt_pkg, hbt_cfg, hbt_ctrl, hbt_dp
//
// usage:
//   s_* carries one pixel item per cycle while s_tready is high; s_tlast
//   marks the final pixel of a frame. m_* returns one threshold level per
//   frame. apb sets pixel_budget at offset 0 (default 628).
//   pixels are counted into BINS bins at one item per cycle while s_tready
//   is high; the bin update is a read-modify-write on the bin memory with a
//   write bypass. after the last pixel, s_tready drops: a drain state, then
//   the bins are read from BINS-1 down to 1, one read per cycle, and the scan
//   stops at the first bin where the saturating sum exceeds the budget (level
//   is BINS-1 if none does). pixel updates and the scan share the single read
//   port of the bin memory.
//   the level waits in an output register; the histogram is cleared when the
//   level is loaded, and s_tready returns the next cycle.
//   if the receiver stalls, the next frame is taken and its level waits
//   until the previous one is taken.
//   reset: empty histogram, no result pending, budget at its default.
module histogram_bright_threshold #(
    parameter int BINS       = hbt_pkg::HbtBins,
    parameter int COUNT_BITS = hbt_pkg::HbtCountBits
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel
    input  logic                              s_tlast,   // last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] level
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hbt_pkg::ApbAddrBits-1:0]   paddr,
    input  logic [hbt_pkg::ApbDataBits-1:0]   pwdata,
    output logic [hbt_pkg::ApbDataBits-1:0]   prdata,
    output logic                              pready
);
    import hbt_pkg::*;

    logic [BudgetBits-1:0] pixel_budget;
    hbt_cmd_t              cmd;
    hbt_sts_t              sts;

    hbt_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_budget (pixel_budget)
    );

    hbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hbt_dp #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (s_tdata[PixelBits-1:0]),
        .pixel_budget (pixel_budget),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .level        (m_tdata[LevelBits-1:0]),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

### tb/sv/tb_histogram_bright_threshold.sv
// tb_histogram_bright_threshold: self-checking bench for the bright-level
// histogram threshold block; predicts each frame's level and checks m_* items
// depends on hbt_pkg and histogram_bright_threshold
`timescale 1ns / 1ps

module tb_histogram_bright_threshold;

    import hbt_pkg::*;

    localparam int RegPixelBudget = 0;
    localparam int RegUnused      = 1;
    localparam logic [ApbAddrBits-1:0] BudgetAddr = ApbAddrBits'(RegPixelBudget * 4);
    localparam logic [ApbAddrBits-1:0] UnusedAddr = ApbAddrBits'(RegUnused * 4);
    localparam logic [BudgetBits-1:0]  BudgetMax  = '1;
    localparam logic [SumBits:0]       SumMax     = (SumBits + 1)'((1 << SumBits) - 1);
    localparam int DrainCycles   = HbtBins + 16;
    localparam int RandomPixels  = 750;

    typedef struct packed {
        logic [PixelBits-1:0] pixel;
        logic                 last;
    } pixel_item_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ApbAddrBits-1:0] paddr    = '0;
    logic [ApbDataBits-1:0] pwdata   = '0;
    logic [ApbDataBits-1:0] prdata;
    logic                   pready;

    pixel_item_t          pixel_q[$];
    logic [LevelBits-1:0] level_q[$];
    logic [HbtCountBits-1:0] bin_tally[HbtBins];
    logic [BudgetBits-1:0]   budget_now = BudgetReset;
    bit                   gapless = 1'b0;
    int                   mismatches = 0;

    histogram_bright_threshold DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // top-down scan over bins 255..1, saturating sum, first bin above budget
    function automatic logic [LevelBits-1:0] bright_level();
        logic [SumBits:0] acc;
        acc = '0;
        for (int b = HbtBins - 1; b > 0; b--)
        begin
            acc = acc + bin_tally[b];
            if (acc > SumMax)
                acc = SumMax;
            if (acc > budget_now)
                return LevelBits'(b);
        end
        return LevelBits'(HbtBins - 1);
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        pixel_item_t item_now;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pixel_q.size() != 0 && (gapless || $urandom_range(99) >= 11))
            begin
                item_now = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item_now.pixel;
                s_tlast  <= item_now.last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // level receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= gapless || ($urandom_range(99) >= 11);
    end

    initial
    begin
        foreach (bin_tally[i])
            bin_tally[i] = '0;
    end

    // histogram model, budget copy and level check
    always @(posedge clk)
    begin
        logic [LevelBits-1:0] want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == RegPixelBudget)
                budget_now = pwdata[BudgetBits-1:0];
            if (s_tvalid && s_tready)
            begin
                if (bin_tally[s_tdata] != '1)
                    bin_tally[s_tdata] = bin_tally[s_tdata] + 1'b1;
                if (s_tlast)
                begin
                    level_q = {level_q, bright_level()};
                    foreach (bin_tally[i])
                        bin_tally[i] = '0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (level_q.size() == 0)
                begin
                    $error("unexpected level item: level actual %0d", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = level_q.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("level mismatch: expected %0d, actual %0d", want, m_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic apb_write(input logic [ApbAddrBits-1:0] addr,
                             input logic [ApbDataBits-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read back the budget register and compare with the model copy
    task automatic check_budget();
        logic [ApbDataBits-1:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= BudgetAddr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[BudgetBits-1:0] !== budget_now)
        begin
            $error("pixel_budget mismatch: expected %0d, actual %0d",
                   budget_now, got[BudgetBits-1:0]);
            mismatches++;
        end
    endtask

    task automatic set_budget(input logic [BudgetBits-1:0] value);
        apb_write(BudgetAddr, ApbDataBits'(value));
        check_budget();
    endtask

    // every pixel sent, every level back, scan and clear finished
    task automatic wait_idle();
        while (!(pixel_q.size() == 0 && !s_tvalid && level_q.size() == 0))
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic void add_pixel(input logic [7:0] pixel, input logic last);
        pixel_item_t it;
        it.pixel = pixel;
        it.last  = last;
        pixel_q = {pixel_q, it};
    endfunction

    initial
    begin
        int sent;
        int frames;
        int len;
        int mode;
        int center;
        int phase;
        int quiet_phase;
        logic [7:0] pix;
        logic [BudgetBits-1:0] budget_pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default budget: small frames never exceed it
        check_budget();
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd128, 1'b1);
        wait_idle();

        // write to an unmapped offset must leave the budget alone
        apb_write(UnusedAddr, '0);
        check_budget();

        set_budget('0);
        add_pixel(8'd0, 1'b0);      // bin 0 never counts
        add_pixel(8'd0, 1'b0);
        add_pixel(8'd0, 1'b1);
        add_pixel(8'd1, 1'b1);
        add_pixel(8'h55, 1'b0);
        add_pixel(8'hAA, 1'b0);
        add_pixel(8'h7F, 1'b1);
        add_pixel(8'd255, 1'b1);
        wait_idle();

        set_budget(BudgetBits'(1));
        add_pixel(8'd3, 1'b0);
        add_pixel(8'd200, 1'b0);
        add_pixel(8'd3, 1'b0);
        add_pixel(8'd200, 1'b1);
        wait_idle();

        // no bin can exceed the largest budget
        set_budget(BudgetMax);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd255, 1'b0);
        add_pixel(8'd1, 1'b1);
        wait_idle();

        sent = 0;
        phase = 0;
        quiet_phase = $urandom_range(1, 4);
        while (sent < RandomPixels)
        begin
            case ($urandom_range(9))
                0: budget_pick = '0;
                1: budget_pick = BudgetMax;
                2: budget_pick = BudgetReset;
                3: budget_pick = BudgetBits'($urandom);
                default: budget_pick = BudgetBits'($urandom_range(0, 40));
            endcase
            if ($urandom_range(4) == 0)
                apb_write(UnusedAddr, $urandom);
            set_budget(budget_pick);
            gapless = (phase == quiet_phase);

            frames = $urandom_range(3, 8);
            repeat (frames)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(1, 20);
                mode = $urandom_range(3);
                center = $urandom_range(255);
                for (int k = 0; k < len; k++)
                begin
                    case (mode)
                        0: pix = 8'($urandom_range(255));
                        1: pix = 8'($urandom_range(192, 255));
                        2: pix = 8'($urandom_range(0, 15));
                        default: pix = 8'((center + $urandom_range(0, 6)) & 8'hFF);
                    endcase
                    add_pixel(pix, k == len - 1);
                end
                sent += len;
            end
            wait_idle();
            phase++;
        end
        gapless = 1'b0;

        wait_idle();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
design/hbt_pkg.sv
design/hbt_cfg.sv
design/hbt_ctrl.sv
design/hbt_dp.sv
design/histogram_bright_threshold.sv
tb/sv/tb_histogram_bright_threshold.sv
